// ===== sv/vgsc_pkg.sv =====
// shared types and constants of the voxel grid shape carver
package vgsc_pkg;

  typedef enum logic [3:0] {
    K_PUT_PT  = 4'd0,
    K_CUT_PT  = 4'd1,
    K_PUT_BOX = 4'd2,
    K_CUT_BOX = 4'd3,
    K_PUT_SPH = 4'd4,
    K_CUT_SPH = 4'd5,
    K_PUT_ELL = 4'd6,
    K_CUT_ELL = 4'd7,
    K_READ    = 4'd8
  } kind_t;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;
  localparam logic [1:0] REG_ALPHA = 2'd3;
  localparam int unsigned NUM_REGS = 4;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the transaction
    logic clr_step;  // clearing pass write
    logic wt_step;   // ellipsoid weight multiply step
    logic sweep;     // advance sweep and test one voxel
    logic rd;        // issue read of the point
    logic emit;      // present result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic wt_done;
    logic sweep_done;
    logic pipe_empty;
  } dp_sts_t;

endpackage

// ===== sv/voxel_grid_shape_carver_unit.sv =====
// top level of the voxel grid shape carver
// Each command is one transaction: start while busy is low. Point and read
// commands do not sweep; box, sphere and ellipsoid commands sweep every voxel
// of the grid, one voxel test a cycle, set by the single memory write port.
// Ellipsoids first compute their weights with multiplies.
// Exactly one result per command appears on out_ for one cycle with
// out_strobe high; the receiver cannot stall. After reset a clearing pass
// writes every entry with busy high; configuration writes are taken during it.
module voxel_grid_shape_carver_unit #(
  parameter int unsigned DIM_X = 32,
  parameter int unsigned DIM_Y = 32,
  parameter int unsigned DIM_Z = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] in_kind,
  input  logic [7:0] in_px,
  input  logic [7:0] in_py,
  input  logic [7:0] in_pz,
  input  logic [7:0] in_qx,
  input  logic [7:0] in_qy,
  input  logic [7:0] in_qz,
  input  logic [7:0] in_rad_x,
  input  logic [7:0] in_rad_y,
  input  logic [7:0] in_rad_z,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_strobe,
  output logic       out_voxel_on,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_alpha_out
);

  vgsc_pkg::dp_cmd_t cmd;
  vgsc_pkg::dp_sts_t sts;
  logic [7:0] red_r, green_r, blue_r, alpha_r;

  // paint registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r <= 8'd0; green_r <= 8'd0; blue_r <= 8'd0; alpha_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        vgsc_pkg::REG_RED:   red_r   <= cfg_data;
        vgsc_pkg::REG_GREEN: green_r <= cfg_data;
        vgsc_pkg::REG_BLUE:  blue_r  <= cfg_data;
        vgsc_pkg::REG_ALPHA: alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vgsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_kind),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  vgsc_dp #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_px(in_px), .in_py(in_py), .in_pz(in_pz),
    .in_qx(in_qx), .in_qy(in_qy), .in_qz(in_qz),
    .in_rad_x(in_rad_x), .in_rad_y(in_rad_y), .in_rad_z(in_rad_z),
    .paint({alpha_r, blue_r, green_r, red_r}),
    .out_strobe(out_strobe), .out_voxel_on(out_voxel_on),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_alpha_out(out_alpha_out)
  );

endmodule

// ===== sv/vgsc_ctrl.sv =====
// controller state machine of the voxel grid shape carver
module vgsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [3:0]         kind,
  input  vgsc_pkg::dp_sts_t  sts,
  output vgsc_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WEIGHT, S_SWEEP, S_DRAIN, S_READ, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          busy_nxt = 1'b1;
          case (kind) inside
            [vgsc_pkg::K_PUT_BOX:vgsc_pkg::K_CUT_SPH]: state_nxt = S_SWEEP;
            [vgsc_pkg::K_PUT_ELL:vgsc_pkg::K_CUT_ELL]: state_nxt = S_WEIGHT;
            vgsc_pkg::K_READ:                          state_nxt = S_READ;
            default:                                   state_nxt = S_DRAIN;
          endcase
        end
      end
      S_WEIGHT: begin
        cmd.wt_step = 1'b1;
        if (sts.wt_done) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.pipe_empty) state_nxt = S_EMIT;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== sv/vgsc_dp.sv =====
// datapath of the voxel grid shape carver: sweep, shape tests and voxel memory
module vgsc_dp #(
  parameter int unsigned DIM_X = 32,
  parameter int unsigned DIM_Y = 32,
  parameter int unsigned DIM_Z = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vgsc_pkg::dp_cmd_t cmd,
  output vgsc_pkg::dp_sts_t sts,
  input  logic [3:0]        in_kind,
  input  logic [7:0]        in_px,
  input  logic [7:0]        in_py,
  input  logic [7:0]        in_pz,
  input  logic [7:0]        in_qx,
  input  logic [7:0]        in_qy,
  input  logic [7:0]        in_qz,
  input  logic [7:0]        in_rad_x,
  input  logic [7:0]        in_rad_y,
  input  logic [7:0]        in_rad_z,
  input  logic [31:0]       paint,
  output logic              out_strobe,
  output logic              out_voxel_on,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic [7:0]        out_alpha_out
);

  localparam int unsigned AXB = (DIM_X > 1) ? $clog2(DIM_X) : 1;
  localparam int unsigned AYB = (DIM_Y > 1) ? $clog2(DIM_Y) : 1;
  localparam int unsigned AZB = (DIM_Z > 1) ? $clog2(DIM_Z) : 1;
  localparam int unsigned CELLS = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned AB = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AXB-1:0] XMAX = AXB'(DIM_X - 1);
  localparam logic [AYB-1:0] YMAX = AYB'(DIM_Y - 1);
  localparam logic [AZB-1:0] ZMAX = AZB'(DIM_Z - 1);
  localparam logic [AB-1:0]  AMAX = AB'(CELLS - 1);

  // captured transaction
  logic [3:0] kind_r;
  logic [7:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r, rx_r, ry_r, rz_r;
  logic       put_r;
  logic       no_change;   // shape command that changes nothing
  logic       ell_r;

  // ellipsoid weights: squares at load, then the pairwise products, then the limit
  logic [15:0] sqx_r, sqy_r, sqz_r;
  logic [31:0] wx_r, wy_r, wz_r;
  logic [49:0] lim_r;
  logic [1:0]  wt_cnt_r;

  // sweep counters
  logic [AXB-1:0] x_r;
  logic [AYB-1:0] y_r;
  logic [AZB-1:0] z_r;

  // pipeline
  logic           s1_v_r, s2_v_r, s3_v_r;
  logic [AB-1:0]  s1_a_r, s2_a_r, s3_a_r;
  logic           s1_hit_r;
  logic [15:0]    s1_dx_r, s1_dy_r, s1_dz_r;
  logic [49:0]    s2_tx_r, s2_ty_r, s2_tz_r;
  logic           s2_hit_r, s2_shape_r;
  logic           s3_hit_r;

  // clearing pass
  logic [AB-1:0]  clr_a_r;

  // memory and read path
  logic [32:0]    mem [CELLS];
  logic           rd_v_r, rd_in_r;
  logic [32:0]    rd_q_r;

  function automatic logic [7:0] adiff(input logic [7:0] a, input logic [7:0] b);
    adiff = (a >= b) ? a - b : b - a;
  endfunction

  wire in_grid = ({8'd0, px_r} < 16'(DIM_X)) && ({8'd0, py_r} < 16'(DIM_Y))
              && ({8'd0, pz_r} < 16'(DIM_Z));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      px_r <= in_px; py_r <= in_py; pz_r <= in_pz;
      qx_r <= in_qx; qy_r <= in_qy; qz_r <= in_qz;
      rx_r <= in_rad_x;
      ry_r <= (in_kind[1]) ? in_rad_y : in_rad_x;
      rz_r <= (in_kind[1]) ? in_rad_z : in_rad_x;
      put_r <= ~in_kind[0];
      ell_r <= (in_kind == vgsc_pkg::K_PUT_ELL) || (in_kind == vgsc_pkg::K_CUT_ELL);
      lim_r <= 50'(in_rad_x) * 50'(in_rad_x);
      wx_r <= 32'd1; wy_r <= 32'd1; wz_r <= 32'd1;
      sqx_r <= 16'(in_rad_x) * 16'(in_rad_x);
      sqy_r <= 16'(in_rad_y) * 16'(in_rad_y);
      sqz_r <= 16'(in_rad_z) * 16'(in_rad_z);
    end else if (cmd.wt_step) begin
      case (wt_cnt_r)
        2'd0: begin
          wx_r <= sqy_r * sqz_r;
          wy_r <= sqx_r * sqz_r;
          wz_r <= sqx_r * sqy_r;
        end
        default: lim_r <= 50'(sqx_r) * 50'(wx_r);
      endcase
    end
  end

  // nothing placed: box empty or its low corner outside the grid, zero radius
  always_comb begin
    no_change = 1'b0;
    if (kind_r inside {vgsc_pkg::K_PUT_BOX, vgsc_pkg::K_CUT_BOX}) begin
      no_change = (px_r > qx_r) || (py_r > qy_r) || (pz_r > qz_r) || !in_grid;
    end else begin
      no_change = (rx_r == 8'd0) || (ry_r == 8'd0) || (rz_r == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wt_cnt_r <= '0;
    else if (cmd.wt_step) wt_cnt_r <= wt_cnt_r + 2'd1;
    else wt_cnt_r <= '0;
  end

  // sweep the whole grid; box membership is tested per voxel
  wire last_vox = (x_r == XMAX) && (y_r == YMAX) && (z_r == ZMAX);
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      x_r <= '0; y_r <= '0; z_r <= '0;
    end else if (cmd.sweep) begin
      if (z_r != ZMAX) z_r <= z_r + 1'b1;
      else begin
        z_r <= '0;
        if (y_r != YMAX) y_r <= y_r + 1'b1;
        else begin
          y_r <= '0;
          x_r <= x_r + 1'b1;
        end
      end
    end
  end

  wire [7:0] xv = 8'(x_r);
  wire [7:0] yv = 8'(y_r);
  wire [7:0] zv = 8'(z_r);
  wire is_box = ~kind_r[2];
  wire box_in = (xv >= px_r) && (xv <= qx_r) && (yv >= py_r) && (yv <= qy_r)
             && (zv >= pz_r) && (zv <= qz_r);

  wire [AB-1:0] sw_addr = AB'((32'(x_r) * DIM_Y + 32'(y_r)) * DIM_Z + 32'(z_r));
  wire [AB-1:0] pt_addr = AB'((32'(px_r) * DIM_Y + 32'(py_r)) * DIM_Z + 32'(pz_r));

  wire pt_cmd = (kind_r == vgsc_pkg::K_PUT_PT) || (kind_r == vgsc_pkg::K_CUT_PT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= (cmd.sweep && !no_change) || (cmd.load && (in_kind == vgsc_pkg::K_PUT_PT
                || in_kind == vgsc_pkg::K_CUT_PT));
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // stage 1: squared differences (or point address)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1_a_r   <= AB'((32'(in_px) * DIM_Y + 32'(in_py)) * DIM_Z + 32'(in_pz));
      s1_hit_r <= ({8'd0, in_px} < 16'(DIM_X)) && ({8'd0, in_py} < 16'(DIM_Y))
               && ({8'd0, in_pz} < 16'(DIM_Z));
      s1_dx_r <= '0; s1_dy_r <= '0; s1_dz_r <= '0;
    end else begin
      s1_a_r   <= sw_addr;
      s1_hit_r <= is_box ? box_in : 1'b1;
      s1_dx_r  <= 16'(adiff(xv, px_r)) * 16'(adiff(xv, px_r));
      s1_dy_r  <= 16'(adiff(yv, py_r)) * 16'(adiff(yv, py_r));
      s1_dz_r  <= 16'(adiff(zv, pz_r)) * 16'(adiff(zv, pz_r));
    end
  end

  // stage 2: weighted terms
  always_ff @(posedge clk) begin
    s2_a_r     <= s1_a_r;
    s2_hit_r   <= s1_hit_r;
    s2_shape_r <= !is_box && !pt_cmd;
    s2_tx_r    <= 50'(s1_dx_r) * 50'(wx_r);
    s2_ty_r    <= 50'(s1_dy_r) * 50'(wy_r);
    s2_tz_r    <= 50'(s1_dz_r) * 50'(wz_r);
  end

  // stage 3: sum and compare
  wire [51:0] ssum = 52'(s2_tx_r) + 52'(s2_ty_r) + 52'(s2_tz_r);
  always_ff @(posedge clk) begin
    s3_a_r   <= s2_a_r;
    s3_hit_r <= s2_shape_r ? (ssum < 52'(lim_r)) : s2_hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_a_r <= '0;
    else if (cmd.clr_step) clr_a_r <= clr_a_r + 1'b1;
  end

  // memory write: clearing pass, or a touched voxel
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_a_r] <= '0;
    end else if (s3_v_r && s3_hit_r) begin
      if (put_r) mem[s3_a_r] <= {1'b1, paint};
      else       mem[s3_a_r][32] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0; rd_in_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd;
      if (cmd.rd) rd_in_r <= in_grid;
    end
  end

  logic        st_r;
  logic [32:0] res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= 1'b0;
      res_r <= '0;
    end else begin
      st_r <= cmd.emit;
      if (cmd.load) res_r <= '0;
      else if (rd_v_r && rd_in_r) res_r <= rd_q_r;
    end
  end

  assign sts.clr_done   = (clr_a_r == AMAX);
  assign sts.wt_done    = (wt_cnt_r == 2'd1);
  assign sts.sweep_done = last_vox;
  assign sts.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r && !rd_v_r;

  assign out_strobe    = st_r;
  assign out_voxel_on  = res_r[32];
  assign out_red_out   = res_r[7:0];
  assign out_green_out = res_r[15:8];
  assign out_blue_out  = res_r[23:16];
  assign out_alpha_out = res_r[31:24];

endmodule

// ===== sv/vgsc_chk.sv =====
// port checker for the voxel grid shape carver, bound to the top level
module vgsc_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_voxel_on
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while still busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than a cycle");

  a_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_voxel_on) |-> busy)
    else $error("result changed while idle");

endmodule

bind voxel_grid_shape_carver_unit vgsc_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_voxel_on(out_voxel_on)
);

// ===== test/voxel_grid_shape_carver_unit_tb.sv =====
// self-checking testbench of the voxel grid shape carver top level
module voxel_grid_shape_carver_unit_tb;
  import vgsc_pkg::*;

  localparam int unsigned GX = 32;
  localparam int unsigned GY = 32;
  localparam int unsigned GZ = 32;
  localparam int unsigned NCELLS = GX * GY * GZ;

  typedef struct {
    logic [3:0] kind;
    logic [7:0] px, py, pz, qx, qy, qz, rx, ry, rz;
  } cmd_t;

  typedef struct {
    logic       on;
    logic [7:0] r, g, b, a;
  } voxel_rd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [3:0] in_kind = '0;
  logic [7:0] in_px = '0, in_py = '0, in_pz = '0;
  logic [7:0] in_qx = '0, in_qy = '0, in_qz = '0;
  logic [7:0] in_rad_x = '0, in_rad_y = '0, in_rad_z = '0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       out_strobe;
  logic       out_voxel_on;
  logic [7:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;

  voxel_grid_shape_carver_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_px(in_px), .in_py(in_py), .in_pz(in_pz),
    .in_qx(in_qx), .in_qy(in_qy), .in_qz(in_qz),
    .in_rad_x(in_rad_x), .in_rad_y(in_rad_y), .in_rad_z(in_rad_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_voxel_on(out_voxel_on),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_alpha_out(out_alpha_out)
  );

  // model of the grid and the paint registers
  logic       grid_on [NCELLS];
  logic [7:0] grid_rgba [NCELLS][4];
  logic [7:0] paint [4];

  cmd_t      cmd_queue[$];       // commands waiting to be driven
  voxel_rd_t readback_queue[$];  // results still owed by the block
  int        idle_pct = 24;
  bit        drive_en = 1'b0;
  bit        took = 1'b0;
  int        mismatches = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #200000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned cell_at(int unsigned x, int unsigned y, int unsigned z);
    return (x * GY + y) * GZ + z;
  endfunction

  function automatic void mark(int unsigned n, bit put);
    grid_on[n] = put ? 1'b1 : 1'b0;
    if (put) begin
      for (int c = 0; c < 4; c++) grid_rgba[n][c] = paint[c];
    end
  endfunction

  function automatic longint unsigned dist_sq(int unsigned a, int unsigned b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // carve a sphere or ellipsoid over the whole grid
  function automatic void carve_shape(cmd_t c, bit put, bit ellip);
    longint unsigned ax, ay, az, wx, wy, wz, lim, s;
    ax = c.rx;
    ay = ellip ? c.ry : c.rx;
    az = ellip ? c.rz : c.rx;
    if (ax == 0 || ay == 0 || az == 0) return;
    if (ellip) begin
      wx = ay * ay * az * az;
      wy = ax * ax * az * az;
      wz = ax * ax * ay * ay;
      lim = ax * ax * wx;
    end else begin
      wx = 1; wy = 1; wz = 1;
      lim = ax * ax;
    end
    for (int unsigned x = 0; x < GX; x++)
      for (int unsigned y = 0; y < GY; y++)
        for (int unsigned z = 0; z < GZ; z++) begin
          s = dist_sq(x, c.px) * wx + dist_sq(y, c.py) * wy + dist_sq(z, c.pz) * wz;
          if (s < lim) mark(cell_at(x, y, z), put);
        end
  endfunction

  function automatic void carve_box(cmd_t c, bit put);
    int unsigned x1, y1, z1;
    if (c.px > c.qx || c.py > c.qy || c.pz > c.qz) return;
    if (c.px >= GX || c.py >= GY || c.pz >= GZ) return;
    x1 = (c.qx >= GX) ? GX - 1 : c.qx;
    y1 = (c.qy >= GY) ? GY - 1 : c.qy;
    z1 = (c.qz >= GZ) ? GZ - 1 : c.qz;
    for (int unsigned x = c.px; x <= x1; x++)
      for (int unsigned y = c.py; y <= y1; y++)
        for (int unsigned z = c.pz; z <= z1; z++) mark(cell_at(x, y, z), put);
  endfunction

  // apply one command to the model grid and return its result
  function automatic voxel_rd_t apply_cmd(cmd_t c);
    voxel_rd_t   res;
    bit          in_grid;
    int unsigned n;
    res = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0};
    in_grid = (c.px < GX) && (c.py < GY) && (c.pz < GZ);
    n = cell_at(c.px, c.py, c.pz);
    case (c.kind)
      K_PUT_PT, K_CUT_PT: if (in_grid) mark(n, c.kind == K_PUT_PT);
      K_PUT_BOX, K_CUT_BOX: carve_box(c, c.kind == K_PUT_BOX);
      K_PUT_SPH, K_CUT_SPH: carve_shape(c, c.kind == K_PUT_SPH, 1'b0);
      K_PUT_ELL, K_CUT_ELL: carve_shape(c, c.kind == K_PUT_ELL, 1'b1);
      K_READ: begin
        if (in_grid) begin
          res.on = grid_on[n];
          res.r = grid_rgba[n][0];
          res.g = grid_rgba[n][1];
          res.b = grid_rgba[n][2];
          res.a = grid_rgba[n][3];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // driver: present the next command at the falling edge
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (took) begin
      took = 1'b0;
      void'(cmd_queue.pop_front());
      nxt_start = 1'b0;
    end
    if (drive_en && !nxt_start && cmd_queue.size() > 0 &&
        $urandom_range(99) >= idle_pct) begin
      in_kind  <= cmd_queue[0].kind;
      in_px    <= cmd_queue[0].px;
      in_py    <= cmd_queue[0].py;
      in_pz    <= cmd_queue[0].pz;
      in_qx    <= cmd_queue[0].qx;
      in_qy    <= cmd_queue[0].qy;
      in_qz    <= cmd_queue[0].qz;
      in_rad_x <= cmd_queue[0].rx;
      in_rad_y <= cmd_queue[0].ry;
      in_rad_z <= cmd_queue[0].rz;
      nxt_start = 1'b1;
    end
    start <= nxt_start;
  end

  // monitor: check results first, then predict any accepted transaction
  always @(posedge clk) begin
    voxel_rd_t want;
    cmd_t      c;
    if (rst_n && out_strobe) begin
      if (readback_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = readback_queue.pop_front();
        if (out_voxel_on !== want.on || out_red_out !== want.r ||
            out_green_out !== want.g || out_blue_out !== want.b ||
            out_alpha_out !== want.a) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want on=%0b rgba=%h %h %h %h, got on=%0b rgba=%h %h %h %h",
                     want.on, want.r, want.g, want.b, want.a, out_voxel_on,
                     out_red_out, out_green_out, out_blue_out, out_alpha_out);
        end
      end
    end
    if (rst_n && start && !busy) begin
      c = cmd_queue[0];
      readback_queue.push_back(apply_cmd(c));
      took = 1'b1;
    end
  end

  function automatic cmd_t mk(logic [3:0] k, logic [7:0] px, logic [7:0] py, logic [7:0] pz,
                              logic [7:0] qx, logic [7:0] qy, logic [7:0] qz,
                              logic [7:0] rx, logic [7:0] ry, logic [7:0] rz);
    cmd_t c;
    c.kind = k; c.px = px; c.py = py; c.pz = pz;
    c.qx = qx; c.qy = qy; c.qz = qz; c.rx = rx; c.ry = ry; c.rz = rz;
    return c;
  endfunction

  // mostly in-grid coordinates, sometimes the full field range
  function automatic logic [7:0] coord();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(GX - 1));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned sel;
    sel = $urandom_range(99);
    c = mk(K_READ, coord(), coord(), coord(), coord(), coord(), coord(),
           8'($urandom_range(12)), 8'($urandom_range(12)), 8'($urandom_range(12)));
    if ($urandom_range(7) == 0) begin
      c.rx = 8'($urandom); c.ry = 8'($urandom); c.rz = 8'($urandom);
    end
    // sweeps cost a whole grid pass, so keep them to about one in nine
    if (sel < 36)      c.kind = K_READ;
    else if (sel < 58) c.kind = K_PUT_PT;
    else if (sel < 72) c.kind = K_CUT_PT;
    else if (sel < 78) c.kind = 4'($urandom_range(15, 9));
    else if (sel < 82) c.kind = $urandom_range(1) ? K_PUT_BOX : K_CUT_BOX;
    else if (sel < 86) c.kind = $urandom_range(1) ? K_PUT_SPH : K_CUT_SPH;
    else if (sel < 89) c.kind = $urandom_range(1) ? K_PUT_ELL : K_CUT_ELL;
    if (c.kind == K_PUT_BOX || c.kind == K_CUT_BOX) begin
      c.qx = c.px + 8'($urandom_range(8));
      c.qy = c.py + 8'($urandom_range(8));
      c.qz = c.pz + 8'($urandom_range(8));
      if ($urandom_range(3) == 0) c.qz = 8'($urandom);
    end
    return c;
  endfunction

  // wait until every command is through and the block is quiet
  task automatic drain();
    do @(negedge clk);
    while (cmd_queue.size() > 0 || start || readback_queue.size() > 0 || busy);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    logic [7:0] vals [4];
    logic [1:0] idx [4];
    vals = '{r, g, b, a};
    idx = '{REG_RED, REG_GREEN, REG_BLUE, REG_ALPHA};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      paint[idx[i]] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) cmd_queue.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    for (int n = 0; n < NCELLS; n++) begin
      grid_on[n] = 1'b0;
      for (int c = 0; c < 4; c++) grid_rgba[n][c] = 8'd0;
    end
    paint = '{8'd0, 8'd0, 8'd0, 8'd255};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // let the clearing pass finish before the first transaction
    do @(negedge clk);
    while (busy);
    drive_en = 1'b1;

    // directed part, reset colours first
    idle_pct = 24;
    cmd_queue.push_back(mk(K_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(K_PUT_PT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(K_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    set_paint(8'hff, 8'h00, 8'haa, 8'h55);
    cmd_queue.push_back(mk(K_PUT_PT, 31, 31, 31, 255, 255, 255, 255, 255, 255));
    cmd_queue.push_back(mk(K_READ, 31, 31, 31, 0, 0, 0, 0, 0, 0));
    // point off the grid: no change, read gives zeros
    cmd_queue.push_back(mk(K_PUT_PT, 255, 255, 255, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(K_READ, 32, 0, 0, 0, 0, 0, 0, 0, 0));
    // cut keeps the colour
    cmd_queue.push_back(mk(K_CUT_PT, 31, 31, 31, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(K_READ, 31, 31, 31, 0, 0, 0, 0, 0, 0));
    // box clipped to the grid, then inverted and off-grid boxes
    cmd_queue.push_back(mk(K_PUT_BOX, 30, 0, 5, 255, 3, 40, 0, 0, 0));
    cmd_queue.push_back(mk(K_CUT_BOX, 10, 10, 10, 12, 9, 12, 0, 0, 0));
    cmd_queue.push_back(mk(K_CUT_BOX, 40, 0, 0, 50, 31, 31, 0, 0, 0));
    cmd_queue.push_back(mk(K_READ, 31, 3, 31, 0, 0, 0, 0, 0, 0));
    // zero radius and zero semi-axis
    cmd_queue.push_back(mk(K_PUT_SPH, 16, 16, 16, 0, 0, 0, 0, 9, 9));
    cmd_queue.push_back(mk(K_PUT_ELL, 16, 16, 16, 0, 0, 0, 5, 0, 5));
    // centre outside the grid, large radius
    cmd_queue.push_back(mk(K_PUT_SPH, 200, 40, 0, 0, 0, 0, 180, 0, 0));
    cmd_queue.push_back(mk(K_CUT_ELL, 255, 255, 255, 0, 0, 0, 255, 255, 255));
    cmd_queue.push_back(mk(K_PUT_ELL, 8, 20, 4, 0, 0, 0, 6, 3, 9));
    cmd_queue.push_back(mk(K_CUT_SPH, 0, 31, 0, 0, 0, 0, 7, 0, 0));
    // unused kinds
    cmd_queue.push_back(mk(4'd9, 1, 2, 3, 4, 5, 6, 7, 8, 9));
    cmd_queue.push_back(mk(4'd15, 255, 255, 255, 255, 255, 255, 255, 255, 255));
    cmd_queue.push_back(mk(K_READ, 8, 20, 4, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk(K_READ, 0, 31, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random part over three idling regimes and several paint settings
    set_paint(8'h00, 8'hff, 8'h00, 8'hff);
    run_random(30, 24);
    set_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
    run_random(25, 62);
    set_paint(8'hff, 8'hff, 8'hff, 8'hff);
    run_random(20, 0);

    if (mismatches == 0 && readback_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== voxel_grid_shape_carver_unit.f =====
sv/vgsc_pkg.sv
sv/vgsc_ctrl.sv
sv/vgsc_dp.sv
sv/voxel_grid_shape_carver_unit.sv
sv/vgsc_chk.sv
test/voxel_grid_shape_carver_unit_tb.sv
